### rtl/updq_pkg.sv
// updq_pkg: shared types and constants for the udp port demux queues
// no dependencies
`default_nettype none
package updq_pkg;
   localparam int SOCKET_SLOTS = 8;
   localparam int RING_DEPTH   = 4;
   localparam int DATAGRAM_MAX = 1472;
   localparam int CAPTURE_MAX  = 1024;
   localparam int SLOT_W  = $clog2(SOCKET_SLOTS) > 0 ? $clog2(SOCKET_SLOTS) : 1;
   localparam int RING_W  = $clog2(RING_DEPTH) > 0 ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int ENTRIES = SOCKET_SLOTS * RING_DEPTH;
   localparam int ENTRY_W = $clog2(ENTRIES) > 0 ? $clog2(ENTRIES) : 1;
   localparam int LEN_W   = 11;
   localparam int ENT_DW  = 32 + 16 + LEN_W;
   localparam logic [15:0] EPHEMERAL_BASE = 16'd49152;
   localparam logic [15:0] HDR_LEN = 16'd8;

   typedef enum logic [2:0] {
      REQ_DELIVER = 3'd0, REQ_OPEN = 3'd1, REQ_BIND = 3'd2, REQ_CLOSE = 3'd3,
      REQ_RECEIVE = 3'd4, REQ_ARM = 3'd5, REQ_COLLECT = 3'd6, REQ_SENDTO = 3'd7
   } req_code_type;

   localparam logic [1:0] ST_OK = 2'd0, ST_FAIL = 2'd1, ST_EMPTY = 2'd2;

   // classified request handed from front to back
   typedef struct packed {
      logic [2:0]  code;
      logic [2:0]  sock;
      logic        short_seg;
      logic [15:0] payload;
      logic [15:0] dest_port;
      logic [15:0] origin_port;
      logic [31:0] src_ip;
      logic [15:0] port_value;
      logic [15:0] recv_cap;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        consumed;
      logic        queued;
      logic [2:0]  opened_slot;
      logic [10:0] data_len;
      logic [31:0] from_ip;
      logic [15:0] from_port;
      logic [15:0] source_port;
   } rsp_type;
endpackage
`default_nettype wire

### rtl/updq_ram.sv
// updq_ram: generic single port write, single port registered read memory
// no dependencies
`default_nettype none
module updq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   parameter int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/updq_front.sv
// updq_front: accepts requests, computes payload length, holds a two entry queue
// depends on updq_pkg
`default_nettype none
module updq_front import updq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [2:0]  sock_index,
   input  wire logic [15:0] seg_len,
   input  wire logic [15:0] length_field,
   input  wire logic [15:0] dest_port,
   input  wire logic [15:0] origin_port,
   input  wire logic [31:0] src_ip,
   input  wire logic [15:0] port_value,
   input  wire logic [15:0] recv_cap,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  wire logic        cmd_take
);
   cmd_type q_ff [2];
   logic    wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type c;
   logic [15:0] dl;
   logic push;

   always_comb begin
      dl = length_field;
      if (length_field < HDR_LEN || length_field > seg_len) dl = seg_len;
      c.code = req_type; c.sock = sock_index;
      c.short_seg = seg_len < HDR_LEN;
      c.payload = dl - HDR_LEN;
      c.dest_port = dest_port; c.origin_port = origin_port; c.src_ip = src_ip;
      c.port_value = port_value; c.recv_cap = recv_cap;
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push = req_valid && !req_stall;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rp_ff];
   assign wp_in = wp_ff ^ push;
   assign rp_in = rp_ff ^ cmd_take;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= c;
   end
endmodule
`default_nettype wire

### rtl/updq_back.sv
// updq_back: socket table, receive rings and capture slot; one command per cycle
// unless stalled, but none in a ring pop's S_READ; depends on updq_pkg, updq_ram
`default_nettype none
module updq_back import updq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_take,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);
   typedef enum logic [1:0] { S_EXEC = 2'b01, S_READ = 2'b10 } state_type;
   state_type state_ff, state_in;

   logic [SOCKET_SLOTS-1:0] use_ff, use_in;
   logic [15:0] port_ff [SOCKET_SLOTS];
   logic [15:0] port_in [SOCKET_SLOTS];
   logic [RING_W-1:0] head_ff [SOCKET_SLOTS];
   logic [RING_W-1:0] head_in [SOCKET_SLOTS];
   logic [CNT_W-1:0]  cnt_ff [SOCKET_SLOTS];
   logic [CNT_W-1:0]  cnt_in [SOCKET_SLOTS];
   logic [15:0] eph_ff, eph_in;
   logic cap_arm_ff, cap_arm_in, cap_full_ff, cap_full_in;
   logic [15:0] cap_port_ff, cap_port_in;
   logic [31:0] cap_ip_ff, cap_ip_in;
   logic [10:0] cap_len_ff, cap_len_in;
   logic rv_ff, rv_in;
   rsp_type r_ff, r_in;
   logic [15:0] pcap_ff;

   logic we;
   logic [ENTRY_W-1:0] waddr, raddr;
   logic [ENT_DW-1:0] wdata, rdata;

   updq_ram #(.WIDTH(ENT_DW), .DEPTH(ENTRIES)) u_ring (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata));

   logic can_go, hit, valid, taken, found;
   logic [SLOT_W-1:0] hs, fs, si;
   logic [RING_W-1:0] pos;
   logic [10:0] rlen;

   assign can_go = !rv_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      use_in = use_ff; port_in = port_ff; head_in = head_ff; cnt_in = cnt_ff;
      eph_in = eph_ff; cap_arm_in = cap_arm_ff; cap_full_in = cap_full_ff;
      cap_port_in = cap_port_ff; cap_ip_in = cap_ip_ff; cap_len_in = cap_len_ff;
      rv_in = rv_ff && rsp_stall; r_in = r_ff;
      cmd_take = 1'b0; we = 1'b0; waddr = '0; raddr = '0; wdata = '0;
      hit = 1'b0; hs = '0; found = 1'b0; fs = '0; taken = 1'b0; pos = '0;
      si = cmd.sock[SLOT_W-1:0];
      valid = {29'd0, cmd.sock} < SOCKET_SLOTS;
      rlen = rdata[LEN_W-1:0];
      // first in-use slot matching port, and first free slot
      for (int i = SOCKET_SLOTS - 1; i >= 0; i--) begin
         if (use_ff[i] && port_ff[i] == cmd.dest_port) begin hit = 1'b1; hs = SLOT_W'(i); end
         if (!use_ff[i]) begin found = 1'b1; fs = SLOT_W'(i); end
         if (SLOT_W'(i) != si && use_ff[i] && cmd.port_value != 16'd0
             && port_ff[i] == cmd.port_value) taken = 1'b1;
      end
      unique case (state_ff)
         S_EXEC: if (cmd_valid && can_go) begin
            r_in = '0;
            unique case (cmd.code)
               REQ_DELIVER: begin
                  r_in.consumed = 1'b1;
                  if (!cmd.short_seg) begin
                     if (hit) begin
                        if (cnt_ff[hs] < CNT_W'(RING_DEPTH)) begin
                           pos = RING_W'((32'(head_ff[hs]) + 32'(cnt_ff[hs])) % RING_DEPTH);
                           we = 1'b1;
                           waddr = ENTRY_W'(32'(hs) * RING_DEPTH + 32'(pos));
                           wdata = {cmd.src_ip, cmd.origin_port,
                              (cmd.payload > 16'(DATAGRAM_MAX)) ? 11'(DATAGRAM_MAX)
                                                               : cmd.payload[10:0]};
                           cnt_in[hs] = cnt_ff[hs] + 1'b1;
                           r_in.queued = 1'b1;
                        end
                     end else if (cap_arm_ff && cmd.dest_port == cap_port_ff) begin
                        if (!cap_full_ff) begin
                           cap_len_in = (cmd.payload > 16'(CAPTURE_MAX)) ? 11'(CAPTURE_MAX)
                                                                         : cmd.payload[10:0];
                           cap_ip_in = cmd.src_ip; cap_full_in = 1'b1;
                           r_in.queued = 1'b1;
                        end
                     end else r_in.consumed = 1'b0;
                  end
               end
               REQ_OPEN: begin
                  r_in.status = ST_FAIL;
                  if (found) begin
                     use_in[fs] = 1'b1; port_in[fs] = '0; head_in[fs] = '0; cnt_in[fs] = '0;
                     r_in.opened_slot = 3'(fs); r_in.status = ST_OK;
                  end
               end
               REQ_BIND: begin
                  r_in.status = ST_FAIL;
                  if (valid && use_ff[si] && !taken) begin
                     port_in[si] = cmd.port_value; r_in.status = ST_OK;
                  end
               end
               REQ_CLOSE: if (valid) use_in[si] = 1'b0;
               REQ_RECEIVE: begin
                  if (!valid || !use_ff[si]) r_in.status = ST_FAIL;
                  else if (cnt_ff[si] == '0) r_in.status = ST_EMPTY;
                  else begin
                     raddr = ENTRY_W'(32'(si) * RING_DEPTH + 32'(head_ff[si]));
                     head_in[si] = RING_W'((32'(head_ff[si]) + 1) % RING_DEPTH);
                     cnt_in[si] = cnt_ff[si] - 1'b1;
                     state_in = S_READ;
                  end
               end
               REQ_ARM: begin
                  cap_port_in = cmd.port_value; cap_len_in = '0; cap_ip_in = '0;
                  cap_full_in = 1'b0; cap_arm_in = 1'b1;
               end
               REQ_COLLECT: begin
                  if (!cap_full_ff) r_in.status = ST_EMPTY;
                  else begin
                     r_in.data_len = ({5'd0, cap_len_ff} < cmd.recv_cap) ? cap_len_ff
                                                                         : cmd.recv_cap[10:0];
                     r_in.from_ip = cap_ip_ff; cap_arm_in = 1'b0;
                  end
               end
               REQ_SENDTO: begin
                  if (!valid || !use_ff[si]) r_in.status = ST_FAIL;
                  else if (port_ff[si] == '0) begin
                     port_in[si] = eph_ff;
                     eph_in = (eph_ff == 16'hFFFF) ? EPHEMERAL_BASE : eph_ff + 16'd1;
                     r_in.source_port = eph_ff;
                  end else r_in.source_port = port_ff[si];
               end
               default: ;
            endcase
            cmd_take = 1'b1;
            rv_in = state_in == S_EXEC;
         end
         S_READ: begin
            // entry read returns; result slot is already free
            r_in.data_len = ({5'd0, rlen} < pcap_ff) ? rlen : pcap_ff[10:0];
            r_in.from_ip = rdata[ENT_DW-1 -: 32];
            r_in.from_port = rdata[LEN_W +: 16];
            rv_in = 1'b1;
            state_in = S_EXEC;
         end
         default: state_in = S_EXEC;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp = r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_EXEC; use_ff <= '0; eph_ff <= EPHEMERAL_BASE;
         cap_arm_ff <= 1'b0; cap_full_ff <= 1'b0; cap_port_ff <= '0;
         cap_ip_ff <= '0; cap_len_ff <= '0; rv_ff <= 1'b0;
         for (int i = 0; i < SOCKET_SLOTS; i++) begin
            port_ff[i] <= '0; head_ff[i] <= '0; cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; use_ff <= use_in; eph_ff <= eph_in;
         cap_arm_ff <= cap_arm_in; cap_full_ff <= cap_full_in; cap_port_ff <= cap_port_in;
         cap_ip_ff <= cap_ip_in; cap_len_ff <= cap_len_in; rv_ff <= rv_in;
         port_ff <= port_in; head_ff <= head_in; cnt_ff <= cnt_in;
      end
      r_ff <= r_in;
      if (cmd_take) pcap_ff <= cmd.recv_cap;
   end
endmodule
`default_nettype wire

### rtl/udp_port_demux_queues_core.sv
// udp_port_demux_queues_core: top level, front queue plus socket back end
// depends on updq_pkg, updq_front, updq_back, updq_ram
// path: front queue, then back end result register; a ring pop also passes S_READ
// throughput: one request per cycle for most codes when rsp_stall is low; a receive
//   with data takes no new command in S_READ as the ring memory read is registered
// reset: synchronous, clears socket table, ring counters, capture slot and queue;
//   ring entry memory is not cleared, entries are written before they are read
`default_nettype none
module udp_port_demux_queues_core import updq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [2:0]  req_sock_index,
   input  wire logic [15:0] req_seg_len,
   input  wire logic [15:0] req_length_field,
   input  wire logic [15:0] req_dest_port,
   input  wire logic [15:0] req_origin_port,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [15:0] req_port_value,
   input  wire logic [15:0] req_recv_cap,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_consumed,
   output logic             rsp_queued,
   output logic [2:0]       rsp_opened_slot,
   output logic [10:0]      rsp_data_len,
   output logic [31:0]      rsp_from_ip,
   output logic [15:0]      rsp_from_port,
   output logic [15:0]      rsp_source_port
);
   // classified commands waiting for the back end
   logic    cmd_valid, cmd_take;
   cmd_type cmd;
   rsp_type rsp;

   updq_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .sock_index(req_sock_index), .seg_len(req_seg_len),
      .length_field(req_length_field), .dest_port(req_dest_port),
      .origin_port(req_origin_port), .src_ip(req_src_ip), .port_value(req_port_value),
      .recv_cap(req_recv_cap), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take));

   // socket table, rings and capture slot
   updq_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_take(cmd_take), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp));

   assign rsp_status      = rsp.status;
   assign rsp_consumed    = rsp.consumed;
   assign rsp_queued      = rsp.queued;
   assign rsp_opened_slot = rsp.opened_slot;
   assign rsp_data_len    = rsp.data_len;
   assign rsp_from_ip     = rsp.from_ip;
   assign rsp_from_port   = rsp.from_port;
   assign rsp_source_port = rsp.source_port;
endmodule
`default_nettype wire
